// ===== src/perceptron_online_trainer_top_defines.svh =====
// Assertion macros shared by the perceptron trainer RTL.
`ifndef PERCEPTRON_ONLINE_TRAINER_TOP_DEFINES_SVH
`define PERCEPTRON_ONLINE_TRAINER_TOP_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define POT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Clocked check that also runs through reset.
`define POT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pot_pkg.sv =====
// Types, constants and helpers for the perceptron trainer.
`default_nettype none

package pot_pkg;

  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned TALLY_W   = 32;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned LO_W      = 20;
  localparam int unsigned MUL_B_W   = SUM_W - LO_W + 1;
  localparam int unsigned MUL_W     = WEIGHT_W + MUL_B_W;
  localparam int unsigned PROD_W    = MUL_W + LO_W;
  localparam int unsigned SCORE_W   = 48;
  localparam int unsigned GRP_SIZE  = 16;

  localparam logic [CFG_W-1:0] VALUE_RESET = 31'd3063020;
  localparam logic [CFG_W-1:0] FSTEP_RESET = 31'd3063020;
  localparam logic [CFG_W-1:0] BSTEP_RESET = 31'd16777216;

  typedef enum logic [TYPE_W-1:0] {
    REQ_WRITE   = 3'd0,
    REQ_FEATURE = 3'd1,
    REQ_END     = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_READ    = 3'd4
  } pot_req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_VALUE = 2'd0,
    CFG_FEATURE_STEP  = 2'd1,
    CFG_BIAS_STEP     = 2'd2
  } pot_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_USE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_SCORE,
    ST_UPDATE,
    ST_RESP
  } pot_state_e;

  typedef struct packed {
    logic [TYPE_W-1:0]          req_type;
    logic [IDX_W-1:0]           feature_index;
    logic signed [WEIGHT_W-1:0] weight_in;
    logic                       label_positive;
  } pot_req_t;

  typedef struct packed {
    logic                       predicted_positive;
    logic                       mistake;
    logic [TALLY_W-1:0]         right_count;
    logic [TALLY_W-1:0]         wrong_count;
    logic signed [WEIGHT_W-1:0] weight_out;
  } pot_rsp_t;

  typedef struct packed {
    logic                       wr_en;
    logic                       mark_en;
    logic                       upd_en;
    logic                       clr_en;
    logic signed [WEIGHT_W-1:0] wdata;
    logic signed [WEIGHT_W-1:0] step;
  } pot_cmd_t;

  typedef struct packed {
    logic                       present;
    logic signed [WEIGHT_W-1:0] weight;
  } pot_rd_t;

  function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [WEIGHT_W:0] v);
    logic signed [WEIGHT_W-1:0] r;
    if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
      r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else begin
      r = v[WEIGHT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/perceptron_online_trainer_top.sv =====
// Perceptron trainer top: request sequencer, score datapath, tallies, output register.
//
// Usage:
//   in_* channel (valid/ready) carries requests: write weight, present feature,
//   end of example, clear counts, read weight. Every accepted request yields
//   exactly one response on the out_* channel (valid/ready), in order.
//   cfg_we_i writes feature_value, feature_step or bias_step at cfg_idx_i;
//   write only while no request is in flight.
//   One request is worked at a time. Write, clear and other requests go
//   straight to the response step; feature and read of a cell pass the
//   grouped read chain of the cell row, registered per group and again at its
//   output, then accumulate; end of example makes two passes of the shared
//   32x21 multiplier, a combine, the score compare, then an update step in
//   which, on a mistake, all marked cells update at once. The next request is
//   taken the cycle after the response is loaded. A stalled receiver holds the
//   response in the output register; the sequencer waits in its response step
//   until that register frees. Reset clears all weights, present flags, sum and
//   tallies, and restores the configuration registers to their defaults.
`default_nettype none
`include "perceptron_online_trainer_top_defines.svh"

module perceptron_online_trainer_top import pot_pkg::*; #(
  parameter int unsigned NUM_FEATURES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pot_req_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pot_rsp_t             out_data_o
);

  localparam int unsigned CMP_W = ($clog2(NUM_FEATURES + 1) > IDX_W) ?
                                  $clog2(NUM_FEATURES + 1) : IDX_W;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  pot_state_e                 state_q, state_d;
  pot_req_t                   req_q, req_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic signed [WEIGHT_W-1:0] bias_q, bias_d;
  logic [TALLY_W-1:0]         right_q, right_d, wrong_q, wrong_d;
  logic [CFG_W-1:0]           value_q, fstep_q, bstep_q;
  logic signed [MUL_W-1:0]    p_lo_q, p_lo_d, p_hi_q, p_hi_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       pred_q, pred_d, miss_q, miss_d;
  logic signed [WEIGHT_W-1:0] wout_q, wout_d;
  logic                       out_valid_q, out_valid_d;
  pot_rsp_t                   out_q, out_d;

  logic                       accept;
  logic                       in_feat, in_bias;
  logic [IDX_W-1:0]           row_idx;
  pot_cmd_t                   cmd;
  pot_rd_t                    rd;
  logic signed [WEIGHT_W-1:0] val_s;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]    mul_res;
  logic signed [SCORE_W-1:0]  score;
  logic                       pos;
  logic signed [SUM_W:0]      acc_sum;
  logic signed [WEIGHT_W-1:0] fstep_s, bstep_s;
  logic                       out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_feat    = CMP_W'(in_data_i.feature_index) < CMP_W'(NUM_FEATURES);
  assign in_bias    = CMP_W'(in_data_i.feature_index) == CMP_W'(NUM_FEATURES);
  assign row_idx    = (state_q == ST_IDLE) ? in_data_i.feature_index : req_q.feature_index;

  assign val_s   = $signed({1'b0, value_q});
  assign mul_b   = (state_q == ST_MUL_HI) ? $signed({sum_q[SUM_W-1], sum_q[SUM_W-1:LO_W]})
                                          : $signed({1'b0, sum_q[LO_W-1:0]});
  assign mul_res = val_s * mul_b;

  assign score = SCORE_W'(prod_q >>> FRAC_W) + SCORE_W'(bias_q);
  assign pos   = !score[SCORE_W-1] && (score != '0);

  assign acc_sum = {sum_q[SUM_W-1], sum_q} + (SUM_W+1)'(rd.weight);

  assign fstep_s = req_q.label_positive ? $signed({1'b0, fstep_q}) : -$signed({1'b0, fstep_q});
  assign bstep_s = req_q.label_positive ? $signed({1'b0, bstep_q}) : -$signed({1'b0, bstep_q});

  pot_row #(
    .NUM_FEATURES (NUM_FEATURES)
  ) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .idx_i  (row_idx),
    .rd_o   (rd)
  );

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    sum_d    = sum_q;
    bias_d   = bias_q;
    right_d  = right_q;
    wrong_d  = wrong_q;
    p_lo_d   = p_lo_q;
    p_hi_d   = p_hi_q;
    prod_d   = prod_q;
    pred_d   = pred_q;
    miss_d   = miss_q;
    wout_d   = wout_q;
    out_load = 1'b0;
    cmd        = '0;
    cmd.wdata  = in_data_i.weight_in;
    cmd.step   = fstep_s;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d  = in_data_i;
          pred_d = 1'b0;
          miss_d = 1'b0;
          wout_d = '0;
          case (in_data_i.req_type)
            REQ_WRITE: begin
              cmd.wr_en = 1'b1;
              if (in_bias) begin
                bias_d = in_data_i.weight_in;
              end
              state_d = ST_RESP;
            end
            REQ_FEATURE: begin
              state_d = in_feat ? ST_LOOK : ST_RESP;
            end
            REQ_END: begin
              state_d = ST_MUL_LO;
            end
            REQ_CLEAR: begin
              right_d = '0;
              wrong_d = '0;
              state_d = ST_RESP;
            end
            REQ_READ: begin
              if (in_feat) begin
                state_d = ST_LOOK;
              end else begin
                if (in_bias) begin
                  wout_d = bias_q;
                end
                state_d = ST_RESP;
              end
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_LOOK: begin
        state_d = ST_USE;
      end
      ST_USE: begin
        if (req_q.req_type == REQ_FEATURE) begin
          if (!rd.present) begin
            cmd.mark_en = 1'b1;
            if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
              sum_d = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
              sum_d = acc_sum[SUM_W-1:0];
            end
          end
        end else begin
          wout_d = rd.weight;
        end
        state_d = ST_RESP;
      end
      ST_MUL_LO: begin
        p_lo_d  = mul_res;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        p_hi_d  = mul_res;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        prod_d  = (PROD_W'(p_hi_q) <<< LO_W) + PROD_W'(p_lo_q);
        state_d = ST_SCORE;
      end
      ST_SCORE: begin
        pred_d  = pos;
        miss_d  = pos != req_q.label_positive;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.clr_en = 1'b1;
        cmd.upd_en = miss_q;
        sum_d      = '0;
        if (miss_q) begin
          bias_d = sat_w({bias_q[WEIGHT_W-1], bias_q} + {bstep_s[WEIGHT_W-1], bstep_s});
          if (wrong_q != '1) begin
            wrong_d = wrong_q + 1'b1;
          end
        end else if (right_q != '1) begin
          right_d = right_q + 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d.predicted_positive = pred_q;
      out_d.mistake            = miss_q;
      out_d.right_count        = right_q;
      out_d.wrong_count        = wrong_q;
      out_d.weight_out         = wout_q;
      out_valid_d              = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      bias_q      <= '0;
      right_q     <= '0;
      wrong_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      bias_q      <= bias_d;
      right_q     <= right_d;
      wrong_q     <= wrong_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= VALUE_RESET;
      fstep_q <= FSTEP_RESET;
      bstep_q <= BSTEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FEATURE_VALUE: value_q <= cfg_data_i;
        CFG_FEATURE_STEP:  fstep_q <= cfg_data_i;
        CFG_BIAS_STEP:     bstep_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    p_lo_q <= p_lo_d;
    p_hi_q <= p_hi_d;
    prod_q <= prod_d;
    pred_q <= pred_d;
    miss_q <= miss_d;
    wout_q <= wout_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `POT_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> ((state_q == ST_IDLE) && !out_valid_q), "reset must leave sequencer idle and output empty")
  `POT_ASSERT(a_sum_cleared, clk_i, rst_ni, (state_q == ST_UPDATE) |=> (sum_q == '0), "partial sum not cleared after end of example")
  `POT_ASSERT(a_one_tally, clk_i, rst_ni, (state_q == ST_UPDATE) |=> ((right_q == $past(right_q)) || (wrong_q == $past(wrong_q))), "both tallies changed on one example")
  `POT_ASSERT(a_resp_wait, clk_i, rst_ni, ((state_q == ST_RESP) && out_valid_q && !out_ready_i) |=> (state_q == ST_RESP), "response left while output register was full")

endmodule

`default_nettype wire

// ===== src/pot_cell.sv =====
// One weight cell: weight, present flag, update adder and read-chain tap.
`default_nettype none

module pot_cell import pot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  pot_cmd_t cmd_i,
  input  logic     hit_i,
  input  pot_rd_t  rd_i,
  output pot_rd_t  rd_o
);

  logic signed [WEIGHT_W-1:0] weight_q, weight_d;
  logic                       present_q, present_d;
  logic signed [WEIGHT_W:0]   upd_sum;

  assign upd_sum = {weight_q[WEIGHT_W-1], weight_q} + {cmd_i.step[WEIGHT_W-1], cmd_i.step};

  always_comb begin
    weight_d  = weight_q;
    present_d = present_q;
    if (cmd_i.wr_en && hit_i) begin
      weight_d = cmd_i.wdata;
    end
    if (cmd_i.mark_en && hit_i) begin
      present_d = 1'b1;
    end
    if (cmd_i.upd_en && present_q) begin
      weight_d = sat_w(upd_sum);
    end
    if (cmd_i.clr_en) begin
      present_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q  <= '0;
      present_q <= 1'b0;
    end else begin
      weight_q  <= weight_d;
      present_q <= present_d;
    end
  end

  assign rd_o.present = rd_i.present | (hit_i & present_q);
  assign rd_o.weight  = rd_i.weight | (hit_i ? weight_q : '0);

endmodule

`default_nettype wire

// ===== src/pot_row.sv =====
// Row of weight cells with a grouped, registered read-back chain.
`default_nettype none

module pot_row import pot_pkg::*; #(
  parameter int unsigned NUM_FEATURES = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pot_cmd_t         cmd_i,
  input  logic [IDX_W-1:0] idx_i,
  output pot_rd_t          rd_o
);

  localparam int unsigned NUM_GROUPS = (NUM_FEATURES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned CMP_W = ($clog2(NUM_FEATURES + 1) > IDX_W) ?
                                  $clog2(NUM_FEATURES + 1) : IDX_W;

  pot_rd_t chain_in  [NUM_FEATURES];
  pot_rd_t chain_out [NUM_FEATURES];
  pot_rd_t grp_q     [NUM_GROUPS];
  pot_rd_t rd_q, rd_d;

  for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_cell
    logic hit;
    assign hit = (CMP_W'(idx_i) == CMP_W'(i));
    if (i % GRP_SIZE == 0) begin : g_head
      assign chain_in[i] = '0;
    end else begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    pot_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_i),
      .hit_i  (hit),
      .rd_i   (chain_in[i]),
      .rd_o   (chain_out[i])
    );
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    localparam int unsigned LAST = (g * GRP_SIZE + GRP_SIZE - 1 < NUM_FEATURES) ?
                                   g * GRP_SIZE + GRP_SIZE - 1 : NUM_FEATURES - 1;
    always_ff @(posedge clk_i) begin
      grp_q[g] <= chain_out[LAST];
    end
  end

  always_comb begin
    rd_d = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      rd_d = rd_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= rd_d;
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// ===== tb/perceptron_checker.sv =====
// Checker for the perceptron trainer: predicts each response from the request stream and compares.
module perceptron_checker import pot_pkg::*; #(
  parameter int unsigned NUM_FEATURES = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  pot_req_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  pot_rsp_t             out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BIAS_INDEX = NUM_FEATURES;
  localparam longint SUM_HI = (64'sd1 <<< 39) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< 39);
  localparam int REPORT_MAX = 10;

  logic signed [WEIGHT_W-1:0] weights [0:NUM_FEATURES];
  logic                       marked  [0:NUM_FEATURES-1];
  longint                     acc_sum;
  logic [TALLY_W-1:0]         right_tally;
  logic [TALLY_W-1:0]         wrong_tally;
  logic [CFG_W-1:0]           feature_value;
  logic [CFG_W-1:0]           feature_step;
  logic [CFG_W-1:0]           bias_step;

  pot_rsp_t predicted_rsp_q [$];
  int       errors;

  function automatic logic signed [WEIGHT_W-1:0] clamp_weight(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[WEIGHT_W-1:0];
  endfunction

  function automatic pot_rsp_t train_step(input pot_req_t r);
    pot_rsp_t           rsp;
    int unsigned        idx;
    longint             s;
    longint             fs;
    longint             bs;
    logic signed [79:0] val_x;
    logic signed [79:0] sum_x;
    logic signed [79:0] bias_x;
    logic signed [79:0] score;
    logic               up;
    rsp = '0;
    idx = 32'(r.feature_index);
    case (r.req_type)
      REQ_WRITE: begin
        if (idx <= BIAS_INDEX) weights[idx] = r.weight_in;
      end
      REQ_FEATURE: begin
        if (idx < NUM_FEATURES && !marked[idx]) begin
          s = acc_sum + longint'(weights[idx]);
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          marked[idx] = 1'b1;
          acc_sum = s;
        end
      end
      REQ_END: begin
        val_x  = {49'd0, feature_value};
        sum_x  = 80'(acc_sum);
        bias_x = 80'(weights[BIAS_INDEX]);
        score  = ((val_x * sum_x) >>> FRAC_W) + bias_x;
        up     = score > 0;
        rsp.predicted_positive = up;
        if (up != r.label_positive) begin
          fs = r.label_positive ? longint'(feature_step) : -longint'(feature_step);
          bs = r.label_positive ? longint'(bias_step) : -longint'(bias_step);
          rsp.mistake = 1'b1;
          for (int i = 0; i < NUM_FEATURES; i++) begin
            if (marked[i]) weights[i] = clamp_weight(longint'(weights[i]) + fs);
          end
          weights[BIAS_INDEX] = clamp_weight(longint'(weights[BIAS_INDEX]) + bs);
          if (wrong_tally != '1) wrong_tally++;
        end else begin
          if (right_tally != '1) right_tally++;
        end
        for (int i = 0; i < NUM_FEATURES; i++) marked[i] = 1'b0;
        acc_sum = 0;
      end
      REQ_CLEAR: begin
        right_tally = '0;
        wrong_tally = '0;
      end
      REQ_READ: begin
        if (idx <= BIAS_INDEX) rsp.weight_out = weights[idx];
      end
      default: ;
    endcase
    rsp.right_count = right_tally;
    rsp.wrong_count = wrong_tally;
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NUM_FEATURES; i++) weights[i] = '0;
      for (int i = 0; i < NUM_FEATURES; i++) marked[i] = 1'b0;
      acc_sum       = 0;
      right_tally   = '0;
      wrong_tally   = '0;
      feature_value = VALUE_RESET;
      feature_step  = FSTEP_RESET;
      bias_step     = BSTEP_RESET;
      predicted_rsp_q.delete();
      errors        = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FEATURE_VALUE: feature_value = cfg_data_i;
          CFG_FEATURE_STEP:  feature_step  = cfg_data_i;
          CFG_BIAS_STEP:     bias_step     = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_rsp_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX) begin
            $display("%0t: response transfer with none outstanding", $realtime);
          end
        end else begin
          pot_rsp_t want;
          want = predicted_rsp_q.pop_front();
          if (out_data_i !== want) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              $display("%0t: mismatch want pred=%0d miss=%0d right=%0d wrong=%0d w=%h",
                       $realtime, want.predicted_positive, want.mistake,
                       want.right_count, want.wrong_count, want.weight_out);
              $display("%0t:          got pred=%0d miss=%0d right=%0d wrong=%0d w=%h",
                       $realtime, out_data_i.predicted_positive, out_data_i.mistake,
                       out_data_i.right_count, out_data_i.wrong_count,
                       out_data_i.weight_out);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_rsp_q.insert(predicted_rsp_q.size(), train_step(in_data_i));
      end
      pending_o    <= predicted_rsp_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the perceptron trainer testbench: clock, reset, request stimulus and verdict.
module testbench;
  import pot_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_FEATURES = 128;
  localparam logic [IDX_W-1:0] BIAS_INDEX = IDX_W'(NUM_FEATURES);
  localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;
  localparam int SEGMENT_ITEMS = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_FEATURE_VALUE;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  pot_req_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  pot_rsp_t             out_data_o;

  int fail_count;
  int pending;
  int cycles        = 0;
  int items_sent    = 0;
  int send_idle_pct = 31;
  int recv_idle_pct = 78;
  int hold_requests = 0;
  int holds_done    = 0;

  perceptron_online_trainer_top #(
    .NUM_FEATURES(NUM_FEATURES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  perceptron_checker #(
    .NUM_FEATURES(NUM_FEATURES)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("perceptron_online_trainer_top test failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] idx,
                          input logic [WEIGHT_W-1:0] w, input logic lab);
    pot_req_t req;
    req.req_type       = kind;
    req.feature_index  = idx;
    req.weight_in      = w;
    req.label_positive = lab;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // drop valid, wait out all responses and the block's tail latency
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] value, input logic [CFG_W-1:0] fstep,
                          input logic [CFG_W-1:0] bstep);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_FEATURE_VALUE;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FEATURE_STEP;
    cfg_data_i <= fstep;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BIAS_STEP;
    cfg_data_i <= bstep;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int                  target;
    int                  choice;
    int                  k;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] w;
    target = items_sent + n_items;
    while (items_sent < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        repeat (k) begin
          case ($urandom_range(0, 9))
            0:       idx = IDX_W'($urandom_range(NUM_FEATURES, 255));
            1, 2, 3: idx = IDX_W'($urandom_range(0, 15));
            default: idx = IDX_W'($urandom_range(0, NUM_FEATURES - 1));
          endcase
          send_req(REQ_FEATURE, idx, $urandom, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 19) == 0) begin
            send_req(REQ_WRITE, IDX_W'($urandom_range(0, NUM_FEATURES)), $urandom >>> 6,
                     1'($urandom_range(0, 1)));
          end
        end
        send_req(REQ_END, IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end else if (choice < 80) begin
        case ($urandom_range(0, 3))
          0:       w = $urandom;
          1:       w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          default: w = $signed($urandom_range(0, 1 << 26)) - (1 << 25);
        endcase
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 255))
                                          : IDX_W'($urandom_range(0, NUM_FEATURES));
        send_req(REQ_WRITE, idx, w, 1'($urandom_range(0, 1)));
      end else if (choice < 92) begin
        idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 255))
                                          : IDX_W'($urandom_range(0, NUM_FEATURES));
        send_req(REQ_READ, idx, $urandom, 1'($urandom_range(0, 1)));
      end else if (choice < 96) begin
        send_req(REQ_CLEAR, IDX_W'($urandom), $urandom, 1'($urandom_range(0, 1)));
      end else begin
        target++;
        send_req(TYPE_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), IDX_W'($urandom),
                 $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(REQ_READ, BIAS_INDEX, $urandom, 1'b0);
    send_req(REQ_READ, 8'd200, $urandom, 1'b1);
    send_req(REQ_WRITE, 8'd0, 32'h7FFF_FFFF, 1'b0);
    send_req(REQ_WRITE, 8'd1, 32'h8000_0000, 1'b1);
    send_req(REQ_WRITE, BIAS_INDEX, 32'h0100_0000, 1'b0);
    send_req(REQ_WRITE, BIAS_INDEX + 8'd1, 32'h1234_5678, 1'b1);
    send_req(REQ_WRITE, 8'd255, 32'hFFFF_FFFF, 1'b1);
    send_req(REQ_READ, 8'd0, $urandom, 1'b0);
    send_req(REQ_READ, 8'd1, $urandom, 1'b0);
    send_req(REQ_READ, BIAS_INDEX + 8'd1, $urandom, 1'b1);
    send_req(REQ_END, 8'd0, $urandom, 1'b0);
    send_req(REQ_FEATURE, 8'd0, $urandom, 1'b0);
    send_req(REQ_FEATURE, 8'd0, $urandom, 1'b1);
    send_req(REQ_FEATURE, BIAS_INDEX, $urandom, 1'b0);
    send_req(REQ_FEATURE, 8'd255, $urandom, 1'b1);
    send_req(REQ_FEATURE, 8'd2, $urandom, 1'b0);
    send_req(REQ_WRITE, 8'd2, 32'h00FF_0000, 1'b0);
    send_req(REQ_END, 8'd127, $urandom, 1'b1);
    send_req(REQ_FEATURE, 8'd1, $urandom, 1'b0);
    send_req(REQ_END, 8'd0, $urandom, 1'b1);
    send_req(REQ_READ, 8'd1, $urandom, 1'b0);
    send_req(REQ_CLEAR, 8'd0, $urandom, 1'b0);
    send_req(REQ_SPARE_LO, 8'd3, $urandom, 1'b1);
    send_req(REQ_SPARE_HI, 8'd4, $urandom, 1'b0);
    send_req(REQ_FEATURE, 8'd0, $urandom, 1'b1);
    send_req(REQ_END, 8'd0, $urandom, 1'b0);
    send_req(REQ_READ, 8'd0, $urandom, 1'b1);
    settle();

    run_random(SEGMENT_ITEMS);
    settle();
    set_regs('0, '0, '0);
    run_random(SEGMENT_ITEMS);
    settle();

    send_idle_pct = 78;
    recv_idle_pct = 31;
    set_regs(CFG_MAX, CFG_MAX, CFG_MAX);
    run_random(SEGMENT_ITEMS);
    settle();
    set_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_random(SEGMENT_ITEMS);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(VALUE_RESET, CFG_W'($urandom_range(1 << 20, 1 << 25)),
             CFG_W'($urandom_range(1 << 22, 1 << 25)));
    hold_requests++;
    run_random(SEGMENT_ITEMS);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("perceptron_online_trainer_top test passed");
    end else begin
      $display("perceptron_online_trainer_top test failed");
    end
    $finish;
  end

endmodule
